>>> rtl/ohlc_pkg.sv
`default_nettype none

package ohlc_pkg;

    // configuration register
    localparam int CFG_W         = 25;
    localparam logic [CFG_W-1:0] CFG_RESET = 25'd60;

    // bin width in ms: interval * 1000 stays below 2^35
    localparam int BIN_W         = 35;
    // running remainder holds one extra bit for the shifted-in dividend bit
    localparam int REM_W         = BIN_W + 1;
    // restoring-divider bits retired per cycle
    localparam int DIV_STEP_BITS = 3;

    localparam logic OP_TRADE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        FR_IDLE = 3'b001,
        FR_DIV  = 3'b010,
        FR_PUSH = 3'b100
    } front_state_t;

endpackage

`default_nettype wire

>>> rtl/ohlc_candle_aggregator_top.sv
`default_nettype none

// OHLC candle builder for a time-ordered trade stream. Each input word is a
// trade (tuser = 0) or an end-of-stream flush (tuser = 1). Trades with a zero
// time, a zero or negative price, or while the interval register is zero are
// dropped. A kept trade goes to the bin floor(time / bin) * bin with
// bin = interval_seconds * 1000 ms; a trade in a different bin than the open
// candle emits that candle and opens a new one, and a flush emits the open
// candle. The input is ready only while the front end is idle: a kept trade
// holds it while the restoring divider retires three quotient bits per cycle
// to find the bin start and until its entry is pushed, a flush only until its
// entry is pushed, and a dropped trade not at all. A two-entry queue separates
// the divider from the candle update. A result waits in an output register;
// while it waits unaccepted the candle update takes no entries, so the input
// stalls once the queue is full and the front end holds a finished word.
// Write interval_seconds only while the block is idle.
module ohlc_candle_aggregator_top
    import ohlc_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int PRICE_BITS = 48,
    parameter int COUNT_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // trade_time_ms, trade_price
    input  wire logic [((TIME_BITS+PRICE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  wire logic              s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // bar_start_ms, bar_open, bar_high, bar_low, bar_close, bar_trades
    output logic [((TIME_BITS+4*PRICE_BITS+COUNT_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int IN_W    = ((TIME_BITS + PRICE_BITS + 7) / 8) * 8;
    localparam int OUT_W   = ((TIME_BITS + 4 * PRICE_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int ENTRY_W = TIME_BITS + PRICE_BITS + 1;

    logic [TIME_BITS-1:0]  trade_time_ms;
    logic [PRICE_BITS-1:0] trade_price;
    logic                  q_push, q_full, q_pop, q_not_empty;
    logic [ENTRY_W-1:0]    q_push_data, q_pop_data;
    logic [TIME_BITS-1:0]  bar_start_ms;
    logic [PRICE_BITS-1:0] bar_open, bar_high, bar_low, bar_close;
    logic [COUNT_BITS-1:0] bar_trades;
    logic [IN_W-1:0]       in_word;

    assign in_word       = s_axis_tdata;
    assign trade_time_ms = in_word[TIME_BITS-1:0];
    assign trade_price   = in_word[TIME_BITS+PRICE_BITS-1:TIME_BITS];

    ohlc_front #(
        .TIME_BITS  (TIME_BITS),
        .PRICE_BITS (PRICE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (s_axis_tuser),
        .in_time     (trade_time_ms),
        .in_price    (trade_price),
        .push        (q_push),
        .push_data   (q_push_data),
        .full        (q_full)
    );

    ohlc_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    ohlc_back #(
        .TIME_BITS  (TIME_BITS),
        .PRICE_BITS (PRICE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (q_not_empty),
        .entry_data   (q_pop_data),
        .pop          (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .bar_start_ms (bar_start_ms),
        .bar_open     (bar_open),
        .bar_high     (bar_high),
        .bar_low      (bar_low),
        .bar_close    (bar_close),
        .bar_trades   (bar_trades)
    );

    assign m_axis_tdata = OUT_W'({bar_trades, bar_close, bar_low, bar_high,
                                  bar_open, bar_start_ms});

endmodule

`default_nettype wire

>>> rtl/ohlc_fifo.sv
`default_nettype none

module ohlc_fifo #(
    parameter int WIDTH = 97,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ohlc_front.sv
`default_nettype none

module ohlc_front
    import ohlc_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int PRICE_BITS = 48
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [CFG_W-1:0]                cfg_wr_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            in_op,
    input  wire logic [TIME_BITS-1:0]            in_time,
    input  wire logic [PRICE_BITS-1:0]           in_price,
    output logic                                 push,
    // entry: kind, bin start, price (lowest bit up)
    output logic [TIME_BITS+PRICE_BITS:0]        push_data,
    input  wire logic                            full
);

    localparam int STEPS = (TIME_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int DIV_W = STEPS * DIV_STEP_BITS;
    localparam int CNT_W = $clog2(STEPS);

    front_state_t              state_reg, state_next;
    logic [CFG_W-1:0]          interval_reg;
    logic [BIN_W-1:0]          bin_reg, bin_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [DIV_W-1:0]          dvd_reg, dvd_next;
    logic [TIME_BITS-1:0]      time_reg, time_next;
    logic [PRICE_BITS-1:0]     price_reg, price_next;
    logic                      flush_reg, flush_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;

    logic [BIN_W-1:0]          iv_ext, bin_calc;
    logic [REM_W-1:0]          rem_step;
    logic [DIV_W-1:0]          dvd_step;
    logic                      accept, trade_ok;
    logic [TIME_BITS-1:0]      bin_start;

    assign in_ready = (state_reg == FR_IDLE);
    assign accept   = in_valid && in_ready;

    // x1000 = x1024 - x16 - x8
    assign iv_ext   = BIN_W'(interval_reg);
    assign bin_calc = (iv_ext << 10) - (iv_ext << 4) - (iv_ext << 3);

    assign trade_ok = (in_time != '0) && (in_price != '0) && !in_price[PRICE_BITS-1]
                      && (interval_reg != '0);

    // restoring division, remainder only
    always_comb
    begin
        logic [REM_W-1:0] r;
        logic [DIV_W-1:0] d;
        r = rem_reg;
        d = dvd_reg;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            r = {r[REM_W-2:0], d[DIV_W-1]};
            d = {d[DIV_W-2:0], 1'b0};
            if (r >= REM_W'(bin_reg))
            begin
                r = r - REM_W'(bin_reg);
            end
        end
        rem_step = r;
        dvd_step = d;
    end

    assign bin_start = time_reg - TIME_BITS'(rem_reg);
    assign push      = (state_reg == FR_PUSH) && !full;
    assign push_data = {price_reg, bin_start, flush_reg};

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        time_next  = time_reg;
        price_next = price_reg;
        flush_next = flush_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_FLUSH)
                    begin
                        flush_next = 1'b1;
                        rem_next   = '0;
                        time_next  = '0;
                        state_next = FR_PUSH;
                    end
                    else if (trade_ok)
                    begin
                        flush_next = 1'b0;
                        time_next  = in_time;
                        price_next = in_price;
                        dvd_next   = DIV_W'(in_time);
                        rem_next   = '0;
                        bin_next   = bin_calc;
                        cnt_next   = CNT_W'(STEPS - 1);
                        state_next = FR_DIV;
                    end
                end
            end
            FR_DIV:
            begin
                rem_next = rem_step;
                dvd_next = dvd_step;
                if (cnt_reg == '0)
                begin
                    state_next = FR_PUSH;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            FR_PUSH:
            begin
                if (!full)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FR_IDLE;
            interval_reg <= CFG_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        time_reg  <= time_next;
        price_reg <= price_next;
        flush_reg <= flush_next;
        cnt_reg   <= cnt_next;
    end

endmodule

`default_nettype wire

>>> rtl/ohlc_back.sv
`default_nettype none

module ohlc_back #(
    parameter int TIME_BITS  = 48,
    parameter int PRICE_BITS = 48,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            entry_valid,
    input  wire logic [TIME_BITS+PRICE_BITS:0]   entry_data,
    output logic                                 pop,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [TIME_BITS-1:0]                 bar_start_ms,
    output logic [PRICE_BITS-1:0]                bar_open,
    output logic [PRICE_BITS-1:0]                bar_high,
    output logic [PRICE_BITS-1:0]                bar_low,
    output logic [PRICE_BITS-1:0]                bar_close,
    output logic [COUNT_BITS-1:0]                bar_trades
);

    logic                  e_flush;
    logic [TIME_BITS-1:0]  e_start;
    logic [PRICE_BITS-1:0] e_price;

    logic                  open_reg, open_next;
    logic [TIME_BITS-1:0]  cur_start_reg, cur_start_next;
    logic [PRICE_BITS-1:0] cur_open_reg, cur_open_next;
    logic [PRICE_BITS-1:0] cur_high_reg, cur_high_next;
    logic [PRICE_BITS-1:0] cur_low_reg, cur_low_next;
    logic [PRICE_BITS-1:0] cur_close_reg, cur_close_next;
    logic [COUNT_BITS-1:0] cur_count_reg, cur_count_next;

    logic                  out_valid_reg, out_valid_next;
    logic [TIME_BITS-1:0]  o_start_reg, o_start_next;
    logic [PRICE_BITS-1:0] o_open_reg, o_open_next;
    logic [PRICE_BITS-1:0] o_high_reg, o_high_next;
    logic [PRICE_BITS-1:0] o_low_reg, o_low_next;
    logic [PRICE_BITS-1:0] o_close_reg, o_close_next;
    logic [COUNT_BITS-1:0] o_count_reg, o_count_next;
    logic                  emit, start_new;

    assign e_flush = entry_data[0];
    assign e_start = entry_data[TIME_BITS:1];
    assign e_price = entry_data[TIME_BITS+PRICE_BITS:TIME_BITS+1];

    // take an entry only when the output register can hold a possible result
    assign pop = entry_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        emit      = 1'b0;
        start_new = 1'b0;
        open_next      = open_reg;
        cur_start_next = cur_start_reg;
        cur_open_next  = cur_open_reg;
        cur_high_next  = cur_high_reg;
        cur_low_next   = cur_low_reg;
        cur_close_next = cur_close_reg;
        cur_count_next = cur_count_reg;

        if (pop)
        begin
            if (e_flush)
            begin
                emit      = open_reg;
                open_next = 1'b0;
            end
            else if (!open_reg)
            begin
                start_new = 1'b1;
            end
            else if (e_start == cur_start_reg)
            begin
                // prices are positive here, unsigned compare is exact
                if (e_price > cur_high_reg)
                begin
                    cur_high_next = e_price;
                end
                if (e_price < cur_low_reg)
                begin
                    cur_low_next = e_price;
                end
                cur_close_next = e_price;
                if (cur_count_reg != '1)
                begin
                    cur_count_next = cur_count_reg + 1'b1;
                end
            end
            else
            begin
                emit      = 1'b1;
                start_new = 1'b1;
            end
        end

        if (start_new)
        begin
            open_next      = 1'b1;
            cur_start_next = e_start;
            cur_open_next  = e_price;
            cur_high_next  = e_price;
            cur_low_next   = e_price;
            cur_close_next = e_price;
            cur_count_next = COUNT_BITS'(1);
        end

        out_valid_next = out_valid_reg && !out_ready;
        o_start_next   = o_start_reg;
        o_open_next    = o_open_reg;
        o_high_next    = o_high_reg;
        o_low_next     = o_low_reg;
        o_close_next   = o_close_reg;
        o_count_next   = o_count_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            o_start_next   = cur_start_reg;
            o_open_next    = cur_open_reg;
            o_high_next    = cur_high_reg;
            o_low_next     = cur_low_reg;
            o_close_next   = cur_close_reg;
            o_count_next   = cur_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_start_reg <= cur_start_next;
        cur_open_reg  <= cur_open_next;
        cur_high_reg  <= cur_high_next;
        cur_low_reg   <= cur_low_next;
        cur_close_reg <= cur_close_next;
        cur_count_reg <= cur_count_next;
        o_start_reg   <= o_start_next;
        o_open_reg    <= o_open_next;
        o_high_reg    <= o_high_next;
        o_low_reg     <= o_low_next;
        o_close_reg   <= o_close_next;
        o_count_reg   <= o_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign bar_start_ms = o_start_reg;
    assign bar_open     = o_open_reg;
    assign bar_high     = o_high_reg;
    assign bar_low      = o_low_reg;
    assign bar_close    = o_close_reg;
    assign bar_trades   = o_count_reg;

endmodule

`default_nettype wire

>>> tb/tb_ohlc_candle_aggregator_top.sv
`default_nettype none

module tb_ohlc_candle_aggregator_top
    import ohlc_pkg::*;
;

    localparam int TW   = 48;
    localparam int PW   = 48;
    localparam int CW   = 32;
    localparam int S_DW = ((TW + PW + 7) / 8) * 8;
    localparam int M_DW = ((TW + 4 * PW + CW + 7) / 8) * 8;

    localparam int RUN_WORDS     = 600;      // counted words per idling phase
    localparam int SETTLE_CYCLES = 64;       // divider plus queue plus output slack
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_CAP     = 40;
    localparam longint unsigned MS_PER_SEC = 1000;

    localparam logic [TW-1:0] T_MAX    = '1;
    localparam logic [PW-1:0] PX_MAX   = {1'b0, {(PW-1){1'b1}}};
    localparam logic [PW-1:0] PX_NEG   = {1'b1, {(PW-1){1'b0}}};
    localparam logic [PW-1:0] PX_ONE   = PW'(64'h1_0000);
    localparam logic [PW-1:0] PX_TWO   = PW'(64'h2_0000);
    localparam logic [PW-1:0] PX_THREE = PW'(64'h3_0000);
    localparam logic [PW-1:0] PX_FIVE  = PW'(64'h5_0000);

    // packed so that the lowest field sits in the lowest bits of m_axis_tdata
    typedef struct packed {
        logic [CW-1:0] trades;
        logic [PW-1:0] close_px;
        logic [PW-1:0] low_px;
        logic [PW-1:0] high_px;
        logic [PW-1:0] open_px;
        logic [TW-1:0] start_ms;
    } candle_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [CFG_W-1:0]  cfg;
        logic              op;
        logic [TW-1:0]     t;
        logic [PW-1:0]     p;
        logic              typed;
        candle_t           bar;
    } dir_row_t;

    // typed bars list fields as trades, close, low, high, open, start
    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_WORD, '0, OP_FLUSH, 48'd123, 48'd456, 1'b0, '0},    // flush, nothing open
        '{ROW_WORD, '0, OP_TRADE, 48'd0, PX_ONE, 1'b0, '0},       // zero time
        '{ROW_WORD, '0, OP_TRADE, 48'd5, 48'd0, 1'b0, '0},        // zero price
        '{ROW_WORD, '0, OP_TRADE, 48'd5, PX_NEG, 1'b0, '0},       // negative price
        '{ROW_WORD, '0, OP_TRADE, 48'd1, PX_ONE, 1'b0, '0},       // bin at zero
        '{ROW_WORD, '0, OP_TRADE, 48'd59999, PX_MAX, 1'b0, '0},
        '{ROW_WORD, '0, OP_TRADE, 48'd30000, 48'd1, 1'b0, '0},
        '{ROW_WORD, '0, OP_TRADE, 48'd60000, PX_TWO, 1'b1,
          '{32'd3, 48'd1, 48'd1, PX_MAX, PX_ONE, 48'd0}},
        '{ROW_WORD, '0, OP_TRADE, 48'd1000, PX_THREE, 1'b1,      // earlier bin
          '{32'd1, PX_TWO, PX_TWO, PX_TWO, PX_TWO, 48'd60000}},
        '{ROW_WORD, '0, OP_FLUSH, T_MAX, PX_NEG, 1'b1,
          '{32'd1, PX_THREE, PX_THREE, PX_THREE, PX_THREE, 48'd0}},
        '{ROW_WORD, '0, OP_FLUSH, 48'd0, 48'd0, 1'b0, '0},
        '{ROW_WORD, '0, OP_TRADE, T_MAX, PX_FIVE, 1'b0, '0},
        '{ROW_CFG, 25'd0, OP_TRADE, '0, '0, 1'b0, '0},           // zero interval
        '{ROW_WORD, '0, OP_TRADE, 48'd7, PX_ONE, 1'b0, '0},
        '{ROW_WORD, '0, OP_FLUSH, 48'd1, 48'd1, 1'b0, '0},
        '{ROW_CFG, 25'd1, OP_TRADE, '0, '0, 1'b0, '0},
        '{ROW_WORD, '0, OP_TRADE, 48'd999, PX_ONE, 1'b0, '0},
        '{ROW_WORD, '0, OP_TRADE, 48'd1000, 48'd1, 1'b1,
          '{32'd1, PX_ONE, PX_ONE, PX_ONE, PX_ONE, 48'd0}},
        '{ROW_WORD, '0, OP_FLUSH, 48'd0, PX_MAX, 1'b1,
          '{32'd1, 48'd1, 48'd1, 48'd1, 48'd1, 48'd1000}},
        '{ROW_CFG, 25'd31536000, OP_TRADE, '0, '0, 1'b0, '0},
        '{ROW_WORD, '0, OP_TRADE, T_MAX, PX_MAX, 1'b0, '0},
        '{ROW_WORD, '0, OP_TRADE, T_MAX - 48'd1, 48'd1, 1'b0, '0},
        '{ROW_CFG, 25'h1FF_FFFF, OP_TRADE, '0, '0, 1'b0, '0},
        '{ROW_WORD, '0, OP_TRADE, 48'd1, PX_ONE, 1'b0, '0},
        '{ROW_WORD, '0, OP_FLUSH, 48'd0, 48'd0, 1'b0, '0}
    };

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [S_DW-1:0]  s_axis_tdata = '0;
    logic             s_axis_tuser = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [M_DW-1:0]  m_axis_tdata;

    // candle predictor state
    logic             have_candle;
    candle_t          cur_bar;
    logic [CFG_W-1:0] interval_s;

    candle_t          pending_bars[$];
    candle_t          seen_bar;
    candle_t          want_bar;
    int               err_count = 0;
    int               bar_count = 0;
    int               cycle_count = 0;
    int               src_idle_pct = 0;
    int               snk_idle_pct = 0;
    logic [63:0]      mkt_time = 64'd1;

    ohlc_candle_aggregator_top #(
        .TIME_BITS (TW),
        .PRICE_BITS(PW),
        .COUNT_BITS(CW)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ohlc_candle_aggregator_top test failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_below(input logic [63:0] n);
        if (n == 64'd0)
            return 64'd0;
        return rand64() % n;
    endfunction

    // returns 1 when the word closes a candle; the closed candle goes to done
    function automatic logic predict_bar(input logic op, input logic [TW-1:0] t,
                                         input logic [PW-1:0] p, output candle_t done);
        logic [63:0] bin_ms;
        logic [63:0] start;
        logic        emitted;
        done = '0;
        if (op == OP_FLUSH)
        begin
            if (!have_candle)
                return 1'b0;
            done = cur_bar;
            have_candle = 1'b0;
            return 1'b1;
        end
        if (t == '0 || p == '0 || p[PW-1] || interval_s == '0)
            return 1'b0;
        bin_ms = 64'(interval_s) * MS_PER_SEC;
        start = 64'(t) - (64'(t) % bin_ms);
        if (have_candle && TW'(start) == cur_bar.start_ms)
        begin
            if (p > cur_bar.high_px)
                cur_bar.high_px = p;
            if (p < cur_bar.low_px)
                cur_bar.low_px = p;
            cur_bar.close_px = p;
            if (cur_bar.trades != '1)
                cur_bar.trades = cur_bar.trades + 1'b1;
            return 1'b0;
        end
        // any other bin, earlier or later, closes the open candle
        emitted = have_candle;
        done = cur_bar;
        have_candle = 1'b1;
        cur_bar = '{CW'(1), p, p, p, p, TW'(start)};
        return emitted;
    endfunction

    function automatic logic [PW-1:0] pick_price();
        int unsigned r;
        logic [PW-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 3)
            v = PX_MAX;
        else if (r < 6)
            v = PW'(1);
        else if (r < 30)
        begin
            v = PW'(rand64());
            v[PW-1] = 1'b0;
        end
        else
            v = PW'($urandom_range(1, 32'h0FFF_FFFF));
        if (v == '0)
            v = PW'(1);
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_interval();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 40)
            return CFG_W'($urandom_range(1, 3));
        if (r < 60)
            return CFG_W'($urandom_range(4, 300));
        if (r < 70)
            return CFG_W'(60);
        if (r < 78)
            return CFG_W'(31536000);
        if (r < 85)
            return '1;
        return CFG_W'($urandom_range(1, (1 << CFG_W) - 1));
    endfunction

    // mostly a forward-moving trade tape, with flushes, jumps and bad trades mixed in
    task automatic make_market_word(output logic op, output logic [TW-1:0] t,
                                    output logic [PW-1:0] p);
        logic [63:0] bin_ms;
        logic [63:0] step;
        int unsigned r;
        bin_ms = (interval_s == '0) ? MS_PER_SEC : 64'(interval_s) * MS_PER_SEC;
        r = $urandom_range(0, 99);
        op = OP_TRADE;
        p = pick_price();
        t = TW'(mkt_time);
        if (r < 66)
        begin
            if ($urandom_range(0, 3) == 0)
                step = bin_ms + rand_below(bin_ms);
            else
                step = rand_below(bin_ms / 6 + 1);
            mkt_time = mkt_time + step;
            if (mkt_time > 64'(T_MAX) || mkt_time == 64'd0)
                mkt_time = rand_below(64'h1_0000_0000) + 64'd1;
            t = TW'(mkt_time);
        end
        else if (r < 74)
        begin
            op = OP_FLUSH;
            t = TW'(rand64());
            p = PW'(rand64());
        end
        else if (r < 82)
        begin
            mkt_time = rand64() & 64'(T_MAX);
            if (mkt_time == 64'd0)
                mkt_time = 64'd1;
            t = TW'(mkt_time);
        end
        else if (r < 88)
        begin
            t = '0;
            p = PW'(rand64());
        end
        else if (r < 94)
            p = '0;
        else
        begin
            p = PW'(rand64());
            p[PW-1] = 1'b1;
        end
    endtask

    task automatic send_word(input logic op, input logic [TW-1:0] t, input logic [PW-1:0] p,
                             input logic typed, input candle_t typed_bar);
        candle_t b;
        logic    has;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p, t};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        has = predict_bar(op, t, p, b);
        if (typed)
            pending_bars = {pending_bars, typed_bar};
        else if (has)
            pending_bars = {pending_bars, b};
        @(negedge clk);
    endtask

    // waits until the block has drained, then writes the interval
    task automatic set_interval(input logic [CFG_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_bars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        interval_s = v;
    endtask

    task automatic report_fault(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        if (err_count < PRINT_CAP)
            $display("bar %0d %s: got %h want %h", bar_count, what, got, want);
        err_count++;
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_bar = m_axis_tdata;
            if (pending_bars.size() == 0)
                report_fault("no bar pending, start", 64'(seen_bar.start_ms), 64'd0);
            else
            begin
                want_bar = pending_bars.pop_front();
                if (seen_bar.start_ms !== want_bar.start_ms)
                    report_fault("start_ms", 64'(seen_bar.start_ms), 64'(want_bar.start_ms));
                if (seen_bar.open_px !== want_bar.open_px)
                    report_fault("open", 64'(seen_bar.open_px), 64'(want_bar.open_px));
                if (seen_bar.high_px !== want_bar.high_px)
                    report_fault("high", 64'(seen_bar.high_px), 64'(want_bar.high_px));
                if (seen_bar.low_px !== want_bar.low_px)
                    report_fault("low", 64'(seen_bar.low_px), 64'(want_bar.low_px));
                if (seen_bar.close_px !== want_bar.close_px)
                    report_fault("close", 64'(seen_bar.close_px), 64'(want_bar.close_px));
                if (seen_bar.trades !== want_bar.trades)
                    report_fault("trades", 64'(seen_bar.trades), 64'(want_bar.trades));
            end
            bar_count++;
        end
    end

    initial
    begin
        logic          op;
        logic [TW-1:0] t;
        logic [PW-1:0] p;
        int            sent;
        int            seg;
        int            seg_len;

        have_candle = 1'b0;
        cur_bar = '0;
        interval_s = CFG_RESET;
        src_idle_pct = 17;
        snk_idle_pct = 66;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TAB[i].kind == ROW_CFG)
                set_interval(DIR_TAB[i].cfg);
            else
                send_word(DIR_TAB[i].op, DIR_TAB[i].t, DIR_TAB[i].p,
                          DIR_TAB[i].typed, DIR_TAB[i].bar);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                src_idle_pct = 66;
                snk_idle_pct = 17;
            end
            else if (ph == 2)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            sent = 0;
            while (sent < RUN_WORDS)
            begin
                set_interval(pick_interval());
                // zero interval drops every trade, so keep that stretch short
                seg_len = (interval_s == '0) ? 12 : 150;
                for (seg = 0; seg < seg_len && sent < RUN_WORDS; seg++)
                begin
                    make_market_word(op, t, p);
                    sent++;
                    send_word(op, t, p, 1'b0, '0);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_bars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("ohlc_candle_aggregator_top test passed");
        else
            $display("ohlc_candle_aggregator_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
